// ===== sv/imhsd_pkg.sv =====
`timescale 1ns / 1ps

package imhsd_pkg;

   localparam int DEF_CAPACITY    = 1023;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam int OP_BITS     = 2;
   localparam int POS_BITS    = 10;
   localparam int KEY_BITS    = 10;
   localparam int WFIELD_BITS = 16;
   localparam int MAP_DEPTH   = 1024;
   localparam int UPC_BITS    = 4;

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE = 2'd0,
      OP_SIFT  = 2'd1,
      OP_READ  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef logic [UPC_BITS-1:0] upc_type;

   localparam upc_type U_FETCH = 4'd0;
   localparam upc_type U_DISP  = 4'd1;
   localparam upc_type U_WRITE = 4'd2;
   localparam upc_type U_READ  = 4'd3;
   localparam upc_type U_QUERY = 4'd4;
   localparam upc_type U_ZERO  = 4'd5;
   localparam upc_type U_SIFT0 = 4'd6;
   localparam upc_type U_KIDS  = 4'd7;
   localparam upc_type U_PICK  = 4'd8;
   localparam upc_type U_TEST  = 4'd9;
   localparam upc_type U_MOVEC = 4'd10;
   localparam upc_type U_MOVEP = 4'd11;
   localparam upc_type U_SDONE = 4'd12;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_REQ,
      C_DISPATCH,
      C_NO_LEFT,
      C_NOT_LIGHTER,
      C_EMIT
   } cond_type;

   typedef enum logic [1:0] {
      HR_NONE,
      HR_POS,
      HR_KIDS
   } heap_rd_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_REQ,
      WR_CHILD,
      WR_PARENT
   } wr_sel_type;

   typedef enum logic [2:0] {
      REG_NONE,
      REG_REQ,
      REG_PAR,
      REG_AT,
      REG_CHILD
   } reg_op_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_REQ,
      RES_ZERO,
      RES_HEAP,
      RES_MAP,
      RES_AT
   } res_sel_type;

   typedef struct packed {
      cond_type    cond;
      upc_type     tgt;
      upc_type     alt;
      heap_rd_type heap_rd;
      logic        map_rd;
      wr_sel_type  wr_sel;
      reg_op_type  reg_op;
      res_sel_type res_sel;
      logic        emit;
   } uword_type;

   typedef struct packed {
      uword_type uw;
      logic      advance;
   } ctl_type;

   typedef struct packed {
      op_type op;
      logic   pos_ok;
      logic   no_left;
      logic   not_lighter;
   } status_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [WFIELD_BITS-1:0] weight;
      logic [POS_BITS-1:0]    position;
   } result_type;

   function automatic uword_type ucode(upc_type addr);
      uword_type w;
      unique case (addr)
         U_FETCH: w = '{C_REQ, U_DISP, U_FETCH, HR_NONE, 1'b0, WR_NONE, REG_REQ,
                        RES_HOLD, 1'b0};
         U_DISP:  w = '{C_DISPATCH, U_FETCH, U_DISP, HR_POS, 1'b1, WR_NONE, REG_NONE,
                        RES_HOLD, 1'b0};
         U_WRITE: w = '{C_EMIT, U_FETCH, U_WRITE, HR_NONE, 1'b0, WR_REQ, REG_NONE,
                        RES_REQ, 1'b1};
         U_READ:  w = '{C_EMIT, U_FETCH, U_READ, HR_NONE, 1'b0, WR_NONE, REG_NONE,
                        RES_HEAP, 1'b1};
         U_QUERY: w = '{C_EMIT, U_FETCH, U_QUERY, HR_NONE, 1'b0, WR_NONE, REG_NONE,
                        RES_MAP, 1'b1};
         U_ZERO:  w = '{C_EMIT, U_FETCH, U_ZERO, HR_NONE, 1'b0, WR_NONE, REG_NONE,
                        RES_ZERO, 1'b1};
         U_SIFT0: w = '{C_ALWAYS, U_KIDS, U_KIDS, HR_NONE, 1'b0, WR_NONE, REG_PAR,
                        RES_HEAP, 1'b0};
         U_KIDS:  w = '{C_NO_LEFT, U_SDONE, U_PICK, HR_KIDS, 1'b0, WR_NONE, REG_AT,
                        RES_HOLD, 1'b0};
         U_PICK:  w = '{C_ALWAYS, U_TEST, U_TEST, HR_NONE, 1'b0, WR_NONE, REG_CHILD,
                        RES_HOLD, 1'b0};
         U_TEST:  w = '{C_NOT_LIGHTER, U_SDONE, U_MOVEC, HR_NONE, 1'b0, WR_NONE,
                        REG_NONE, RES_HOLD, 1'b0};
         U_MOVEC: w = '{C_ALWAYS, U_MOVEP, U_MOVEP, HR_NONE, 1'b0, WR_CHILD, REG_NONE,
                        RES_HOLD, 1'b0};
         U_MOVEP: w = '{C_NO_LEFT, U_SDONE, U_PICK, HR_KIDS, 1'b0, WR_PARENT, REG_AT,
                        RES_HOLD, 1'b0};
         U_SDONE: w = '{C_EMIT, U_FETCH, U_SDONE, HR_NONE, 1'b0, WR_NONE, REG_NONE,
                        RES_AT, 1'b1};
         default: w = '{C_ALWAYS, U_FETCH, U_FETCH, HR_NONE, 1'b0, WR_NONE, REG_NONE,
                        RES_HOLD, 1'b0};
      endcase
      return w;
   endfunction

   function automatic upc_type dispatch(op_type op, logic pos_ok);
      upc_type d;
      priority if (op == OP_QUERY) begin
         d = U_QUERY;
      end else if (!pos_ok) begin
         d = U_ZERO;
      end else if (op == OP_WRITE) begin
         d = U_WRITE;
      end else if (op == OP_SIFT) begin
         d = U_SIFT0;
      end else begin
         d = U_READ;
      end
      return d;
   endfunction

endpackage

// ===== sv/imhsd_sequencer.sv =====
`timescale 1ns / 1ps

module imhsd_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   out_free,
   input  imhsd_pkg::status_type  status,
   output imhsd_pkg::ctl_type     ctl
);
   import imhsd_pkg::*;

   upc_type   upc_ff;
   upc_type   upc_in;
   uword_type uw;
   upc_type   dest;
   logic      taken;
   logic      advance;
   logic      accept;

   assign uw        = ucode(upc_ff);
   assign req_stall = (upc_ff != U_FETCH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      taken   = 1'b1;
      advance = 1'b1;
      dest    = uw.tgt;
      unique case (uw.cond)
         C_ALWAYS: begin
            taken = 1'b1;
         end
         C_REQ: begin
            taken   = accept;
            advance = accept;
         end
         C_DISPATCH: begin
            dest = dispatch(status.op, status.pos_ok);
         end
         C_NO_LEFT: begin
            taken = status.no_left;
         end
         C_NOT_LIGHTER: begin
            taken = status.not_lighter;
         end
         C_EMIT: begin
            taken   = out_free;
            advance = out_free;
         end
         default: begin
            taken = 1'b1;
         end
      endcase
      upc_in = taken ? dest : uw.alt;
   end

   assign ctl.uw      = uw;
   assign ctl.advance = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

   a_accept_to_disp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (upc_ff == U_DISP))
      else $error("accepted beat did not go to dispatch");

   a_hold_on_wait: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(upc_ff))
      else $error("step counter moved while waiting");

endmodule

// ===== sv/imhsd_datapath.sv =====
`timescale 1ns / 1ps

module imhsd_datapath #(
   parameter int CAPACITY    = imhsd_pkg::DEF_CAPACITY,
   parameter int WEIGHT_BITS = imhsd_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  imhsd_pkg::ctl_type                  ctl,
   input  logic [imhsd_pkg::OP_BITS-1:0]       req_op,
   input  logic [imhsd_pkg::POS_BITS-1:0]      req_position,
   input  logic [imhsd_pkg::POS_BITS-1:0]      req_heap_size,
   input  logic [imhsd_pkg::KEY_BITS-1:0]      req_key_index,
   input  logic [imhsd_pkg::WFIELD_BITS-1:0]   req_weight,
   output imhsd_pkg::status_type               status,
   output imhsd_pkg::result_type               res_in
);
   import imhsd_pkg::*;

   localparam int SLOTS     = CAPACITY + 1;
   localparam int ADDR_BITS = $clog2(SLOTS);
   localparam int IDX_BITS  = POS_BITS + 1;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [WEIGHT_BITS-1:0] weight;
   } entry_type;

   entry_type heap_mem [SLOTS];
   logic [POS_BITS-1:0] map_mem [MAP_DEPTH];

   uword_type uw;
   logic      advance;

   op_type                 op_ff;
   logic [POS_BITS-1:0]    pos_ff;
   logic [POS_BITS-1:0]    last_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [WEIGHT_BITS-1:0] wt_ff;
   logic [POS_BITS-1:0]    at_ff;
   logic [POS_BITS-1:0]    c_ff;
   entry_type              par_ff;
   entry_type              ch_ff;
   entry_type              rda_ff;
   entry_type              rdb_ff;
   logic [POS_BITS-1:0]    map_rd_ff;
   result_type             res_ff;

   logic [POS_BITS-1:0]    last_in;
   logic                   pos_ok;
   logic [IDX_BITS-1:0]    left_idx;
   logic [IDX_BITS-1:0]    right_idx;
   logic                   left_fits;
   logic                   right_fits;
   logic                   rda_en;
   logic                   rdb_en;
   logic [ADDR_BITS-1:0]   rda_addr;
   logic                   right_wins;
   logic                   hwr_en;
   logic [POS_BITS-1:0]    hwr_idx;
   entry_type              hwr_data;
   logic [KEY_BITS-1:0]    mwr_addr;
   logic [POS_BITS-1:0]    mwr_data;

   assign uw      = ctl.uw;
   assign advance = ctl.advance;

   assign last_in = (32'(req_heap_size) > CAPACITY) ? POS_BITS'(CAPACITY) : req_heap_size;
   assign pos_ok  = (pos_ff != '0) && (32'(pos_ff) <= CAPACITY);

   assign left_idx   = {c_ff, 1'b0};
   assign right_idx  = {c_ff, 1'b1};
   assign left_fits  = (32'(left_idx) <= CAPACITY);
   assign right_fits = (32'(right_idx) <= CAPACITY);

   assign rda_en   = advance && (((uw.heap_rd == HR_POS) && pos_ok) ||
                                 ((uw.heap_rd == HR_KIDS) && left_fits));
   assign rdb_en   = advance && (uw.heap_rd == HR_KIDS) && right_fits;
   assign rda_addr = (uw.heap_rd == HR_POS) ? ADDR_BITS'(pos_ff) : ADDR_BITS'(left_idx);

   // right child only counts when it lies inside the heap; left wins ties
   assign right_wins = ({at_ff, 1'b1} <= {1'b0, last_ff}) && (rdb_ff.weight < rda_ff.weight);

   always_comb begin
      hwr_en   = 1'b0;
      hwr_idx  = pos_ff;
      hwr_data = '{key: key_ff, weight: wt_ff};
      mwr_addr = key_ff;
      mwr_data = pos_ff;
      unique case (uw.wr_sel)
         WR_NONE: begin
            hwr_en = 1'b0;
         end
         WR_REQ: begin
            hwr_en = advance;
         end
         WR_CHILD: begin
            hwr_en   = advance;
            hwr_idx  = at_ff;
            hwr_data = ch_ff;
            mwr_addr = ch_ff.key;
            mwr_data = at_ff;
         end
         WR_PARENT: begin
            hwr_en   = advance;
            hwr_idx  = c_ff;
            hwr_data = par_ff;
            mwr_addr = par_ff.key;
            mwr_data = c_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hwr_en) begin
         heap_mem[ADDR_BITS'(hwr_idx)] <= hwr_data;
      end
      if (rda_en) begin
         rda_ff <= heap_mem[rda_addr];
      end
      if (rdb_en) begin
         rdb_ff <= heap_mem[ADDR_BITS'(right_idx)];
      end
   end

   always_ff @(posedge clock) begin
      if (hwr_en) begin
         map_mem[mwr_addr] <= mwr_data;
      end
      if (advance && uw.map_rd) begin
         map_rd_ff <= map_mem[key_ff];
      end
   end

   always_comb begin
      res_in = res_ff;
      unique case (uw.res_sel)
         RES_HOLD: begin
            res_in = res_ff;
         end
         RES_REQ: begin
            res_in = '{key: key_ff, weight: WFIELD_BITS'(wt_ff), position: pos_ff};
         end
         RES_ZERO: begin
            res_in = '0;
         end
         RES_HEAP: begin
            res_in = '{key: rda_ff.key, weight: WFIELD_BITS'(rda_ff.weight),
                       position: pos_ff};
         end
         RES_MAP: begin
            res_in = '{key: key_ff, weight: '0, position: map_rd_ff};
         end
         RES_AT: begin
            res_in.position = at_ff;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         unique case (uw.reg_op)
            REG_REQ: begin
               op_ff   <= op_type'(req_op);
               pos_ff  <= req_position;
               last_ff <= last_in;
               key_ff  <= req_key_index;
               wt_ff   <= WEIGHT_BITS'(req_weight);
            end
            REG_PAR: begin
               par_ff <= rda_ff;
               c_ff   <= pos_ff;
            end
            REG_AT: begin
               at_ff <= c_ff;
            end
            REG_CHILD: begin
               ch_ff <= right_wins ? rdb_ff : rda_ff;
               c_ff  <= {at_ff[POS_BITS-2:0], right_wins};
            end
            default: begin
            end
         endcase
         res_ff <= res_in;
      end
   end

   assign status.op          = op_ff;
   assign status.pos_ok      = pos_ok;
   assign status.no_left     = ({c_ff, 1'b0} > {1'b0, last_ff});
   assign status.not_lighter = !(ch_ff.weight < par_ff.weight);

   a_child_of_at: assert property (@(posedge clock) disable iff (reset)
      (advance && (uw.reg_op == REG_CHILD)) |=> (c_ff[POS_BITS-1:1] == at_ff[POS_BITS-2:0]))
      else $error("chosen slot is not a child of the current slot");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      hwr_en |-> ((hwr_idx != '0) && (32'(hwr_idx) <= CAPACITY)))
      else $error("heap write outside occupied range");

endmodule

// ===== sv/indexed_min_heap_sift_down.sv =====
// channel  | handshake             | beat fields
// ---------+-----------------------+-----------------------------------------------------
// req      | req_valid / req_stall | op, position, heap_size, key_index, weight
// rsp      | rsp_valid / rsp_stall | out_key, out_weight, out_position
//
// One beat in flight; req_stall is low only while the sequencer waits at its fetch step.
// Write, read and key query go through the fetch, dispatch and one operation step.
// Sift-down: sift0, kids, then pick, test, movec and movep per level moved; the
// single heap write port takes the two swap writes of each level in turn.
// Reset is synchronous; heap slots and the key map are not cleared.
// The result register lets the next beat in while a result waits under rsp_stall.
`timescale 1ns / 1ps

module indexed_min_heap_sift_down #(
   parameter int CAPACITY    = imhsd_pkg::DEF_CAPACITY,
   parameter int WEIGHT_BITS = imhsd_pkg::DEF_WEIGHT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [imhsd_pkg::OP_BITS-1:0]      req_op,
   input  logic [imhsd_pkg::POS_BITS-1:0]     req_position,
   input  logic [imhsd_pkg::POS_BITS-1:0]     req_heap_size,
   input  logic [imhsd_pkg::KEY_BITS-1:0]     req_key_index,
   input  logic [imhsd_pkg::WFIELD_BITS-1:0]  req_weight,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [imhsd_pkg::KEY_BITS-1:0]     rsp_out_key,
   output logic [imhsd_pkg::WFIELD_BITS-1:0]  rsp_out_weight,
   output logic [imhsd_pkg::POS_BITS-1:0]     rsp_out_position
);
   import imhsd_pkg::*;

   ctl_type    ctl;
   status_type status;
   result_type res_in;
   result_type rsp_res_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       load_rsp;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = ctl.advance && ctl.uw.emit;

   imhsd_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .status    (status),
      .ctl       (ctl)
   );

   imhsd_datapath #(
      .CAPACITY    (CAPACITY),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_heap_size (req_heap_size),
      .req_key_index (req_key_index),
      .req_weight    (req_weight),
      .status        (status),
      .res_in        (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_res_ff <= res_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_key      = rsp_res_ff.key;
   assign rsp_out_weight   = rsp_res_ff.weight;
   assign rsp_out_position = rsp_res_ff.position;

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> out_free)
      else $error("result beat overwrote an unaccepted one");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid)
      else $error("finished result not presented");

endmodule

// ===== verif/tb_indexed_min_heap_sift_down.sv =====
`timescale 1ns / 1ps

module tb_indexed_min_heap_sift_down;
   import imhsd_pkg::*;

   class heap_tracker;
      bit [KEY_BITS-1:0]    slot_key    [0:DEF_CAPACITY];
      bit [WFIELD_BITS-1:0] slot_weight [0:DEF_CAPACITY];
      bit                   slot_filled [0:DEF_CAPACITY];
      bit [POS_BITS-1:0]    key_slot    [0:MAP_DEPTH-1];
      bit                   key_known   [0:MAP_DEPTH-1];
      result_type           pending_results[$];
      int unsigned          fails;

      function void place(int pos, bit [KEY_BITS-1:0] key, bit [WFIELD_BITS-1:0] wt);
         slot_key[pos]    = key;
         slot_weight[pos] = wt;
         slot_filled[pos] = 1'b1;
         key_slot[key]    = pos[POS_BITS-1:0];
         key_known[key]   = 1'b1;
      endfunction

      function int sift_from(int at, int last);
         int                   l;
         int                   c;
         bit [KEY_BITS-1:0]    pk;
         bit [WFIELD_BITS-1:0] pw;
         while (at * 2 <= last) begin
            l = at * 2;
            c = l;
            if (l + 1 <= last && slot_weight[l+1] < slot_weight[l]) c = l + 1;
            if (!(slot_weight[c] < slot_weight[at])) break;
            pk = slot_key[at];
            pw = slot_weight[at];
            place(at, slot_key[c], slot_weight[c]);
            place(c, pk, pw);
            at = c;
         end
         return at;
      endfunction

      // true when a sift from this slot only touches slots already written
      function bit sift_safe(int at, int last);
         int                   l;
         int                   c;
         bit [WFIELD_BITS-1:0] w;
         if (at == 0) return 1'b1;
         if (!slot_filled[at]) return 1'b0;
         w = slot_weight[at];
         while (at * 2 <= last) begin
            l = at * 2;
            if (!slot_filled[l]) return 1'b0;
            c = l;
            if (l + 1 <= last) begin
               if (!slot_filled[l+1]) return 1'b0;
               if (slot_weight[l+1] < slot_weight[l]) c = l + 1;
            end
            if (!(slot_weight[c] < w)) return 1'b1;
            at = c;
         end
         return 1'b1;
      endfunction

      function void apply_request(op_type op, bit [POS_BITS-1:0] pos,
                                  bit [POS_BITS-1:0] hsz, bit [KEY_BITS-1:0] key,
                                  bit [WFIELD_BITS-1:0] wt);
         result_type r;
         int         last;
         r    = '0;
         last = (hsz > DEF_CAPACITY) ? DEF_CAPACITY : int'(hsz);
         wt   = wt & WFIELD_BITS'((64'd1 << DEF_WEIGHT_BITS) - 1);
         if (op == OP_QUERY) begin
            r.key      = key;
            r.position = key_slot[key];
         end else if (pos >= 1 && pos <= DEF_CAPACITY) begin
            case (op)
               OP_WRITE: begin
                  place(pos, key, wt);
                  r.key      = key;
                  r.weight   = wt;
                  r.position = pos;
               end
               OP_SIFT: begin
                  r.key      = slot_key[pos];
                  r.weight   = slot_weight[pos];
                  r.position = POS_BITS'(sift_from(pos, last));
               end
               default: begin
                  r.key      = slot_key[pos];
                  r.weight   = slot_weight[pos];
                  r.position = pos;
               end
            endcase
         end
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [KEY_BITS-1:0] k, logic [WFIELD_BITS-1:0] w,
                                 logic [POS_BITS-1:0] p);
         result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected beat: key %h weight %h position %h", $time, k, w, p);
            fails++;
            return;
         end
         want = pending_results.pop_front();
         if (want.key !== k) begin
            $display("%0t out_key: expected %h actual %h", $time, want.key, k);
            fails++;
         end
         if (want.weight !== w) begin
            $display("%0t out_weight: expected %h actual %h", $time, want.weight, w);
            fails++;
         end
         if (want.position !== p) begin
            $display("%0t out_position: expected %h actual %h", $time, want.position, p);
            fails++;
         end
      endfunction
   endclass

   localparam int ITEM_TARGET    = 500;
   localparam int BIG_BUDGET     = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OP_BITS-1:0]     req_op;
   logic [POS_BITS-1:0]    req_position;
   logic [POS_BITS-1:0]    req_heap_size;
   logic [KEY_BITS-1:0]    req_key_index;
   logic [WFIELD_BITS-1:0] req_weight;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [KEY_BITS-1:0]    rsp_out_key;
   logic [WFIELD_BITS-1:0] rsp_out_weight;
   logic [POS_BITS-1:0]    rsp_out_position;

   heap_tracker tracker = new;
   int          beats_in = 0;
   int          quiet_cycles = 0;
   bit          calm = 1'b0;
   bit          big_done = 1'b0;

   indexed_min_heap_sift_down dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_position     (req_position),
      .req_heap_size    (req_heap_size),
      .req_key_index    (req_key_index),
      .req_weight       (req_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_weight   (rsp_out_weight),
      .rsp_out_position (rsp_out_position)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 24);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_result(rsp_out_key, rsp_out_weight, rsp_out_position);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [9:0] rnd10();
      return 10'($urandom_range(0, 1023));
   endfunction

   function automatic logic [15:0] rnd16();
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_weight();
      if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, 3));
      return rnd16();
   endfunction

   function automatic logic [9:0] some_filled_slot();
      logic [9:0] s;
      for (int i = 0; i < 64; i++) begin
         s = 10'($urandom_range(1, DEF_CAPACITY));
         if (tracker.slot_filled[s]) return s;
      end
      return '0;
   endfunction

   task automatic send(op_type op, logic [9:0] pos, logic [9:0] hsz, logic [9:0] key,
                       logic [15:0] wt);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_position  <= pos;
      req_heap_size <= hsz;
      req_key_index <= key;
      req_weight    <= wt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.apply_request(op, pos, hsz, key, wt);
      beats_in++;
      calm = (beats_in >= 200 && beats_in < 300);
   endtask

   // fill slots 1..n, heapify, then pop a few minimums
   task automatic build_and_drain(int n);
      int pops;
      for (int i = 1; i <= n; i++)
         send(OP_WRITE, 10'(i), rnd10(), rnd10(), pick_weight());
      for (int i = n / 2; i >= 1; i--) begin
         send(OP_SIFT, 10'(i), 10'(n), rnd10(), rnd16());
         if ($urandom_range(0, 5) == 0)
            send(OP_READ, 10'($urandom_range(1, n)), rnd10(), rnd10(), rnd16());
      end
      pops = $urandom_range(1, (n + 1) / 2);
      while (pops > 0 && n > 1 && beats_in < ITEM_TARGET) begin
         send(OP_READ, 10'd1, rnd10(), rnd10(), rnd16());
         send(OP_WRITE, 10'd1, rnd10(), tracker.slot_key[n], tracker.slot_weight[n]);
         n--;
         send(OP_SIFT, 10'd1, 10'(n), rnd10(), rnd16());
         if ($urandom_range(0, 3) == 0)
            send(OP_QUERY, rnd10(), rnd10(), tracker.slot_key[1], rnd16());
         pops--;
      end
   endtask

   // usually heavy root over a full-depth path of lighter children
   task automatic deep_path();
      int         at;
      int         l;
      logic [15:0] heavy;
      logic [15:0] wl;
      logic [15:0] wr;
      heavy = ($urandom_range(0, 3) == 0) ? rnd16() : 16'($urandom_range(40000, 65535));
      send(OP_WRITE, 10'd1, rnd10(), rnd10(), heavy);
      at = 1;
      while (2 * at + 1 <= DEF_CAPACITY) begin
         l  = 2 * at;
         wl = 16'($urandom_range(0, 39999));
         case ($urandom_range(0, 2))
            0:       wr = wl;
            1:       wr = 16'($urandom_range(0, 39999));
            default: wr = 16'($urandom_range(wl, 39999));
         endcase
         send(OP_WRITE, 10'(l), rnd10(), rnd10(), wl);
         send(OP_WRITE, 10'(l + 1), rnd10(), rnd10(), wr);
         at = (wr < wl) ? l + 1 : l;
      end
      send(OP_SIFT, 10'd1, ($urandom_range(0, 1) == 0) ? 10'(DEF_CAPACITY)
                                                      : 10'($urandom_range(at, DEF_CAPACITY)),
           rnd10(), rnd16());
   endtask

   task automatic noise_item();
      op_type      op;
      logic [9:0]  pos;
      logic [9:0]  hsz;
      logic [9:0]  key;
      logic [15:0] wt;
      bit          found;
      op  = op_type'($urandom_range(0, 3));
      pos = rnd10();
      hsz = rnd10();
      key = rnd10();
      wt  = rnd16();
      case (op)
         OP_READ: begin
            if (pos != 0 && !tracker.slot_filled[pos]) pos = some_filled_slot();
         end
         OP_SIFT: begin
            if (pos != 0 && !tracker.slot_filled[pos]) pos = some_filled_slot();
            if (!tracker.sift_safe(pos, hsz)) hsz = pos;
         end
         OP_QUERY: begin
            found = tracker.key_known[key];
            for (int i = 0; i < 64 && !found; i++) begin
               key   = rnd10();
               found = tracker.key_known[key];
            end
            if (!found) op = OP_WRITE;
         end
         default: ;
      endcase
      send(op, pos, hsz, key, wt);
   endtask

   initial begin
      int choice;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_WRITE;
      req_position  = '0;
      req_heap_size = '0;
      req_key_index = '0;
      req_weight    = '0;
      rsp_stall     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: slot zero, ties, equal weights, right child, no children
      send(OP_WRITE, 10'd0, 10'd1023, 10'd1023, 16'hFFFF);
      send(OP_WRITE, 10'd1, 10'd0, 10'd1023, 16'hFFFF);
      send(OP_WRITE, 10'd2, 10'd0, 10'd0, 16'h0000);
      send(OP_WRITE, 10'd3, 10'd0, 10'd5, 16'h0000);
      send(OP_QUERY, 10'd0, 10'd1023, 10'd1023, 16'hFFFF);
      send(OP_SIFT, 10'd1, 10'd3, 10'd0, 16'h0000);
      send(OP_READ, 10'd1, 10'd0, 10'd0, 16'h0000);
      send(OP_READ, 10'd2, 10'd0, 10'd0, 16'h0000);
      send(OP_QUERY, 10'd1, 10'd0, 10'd0, 16'h0000);
      send(OP_QUERY, 10'd0, 10'd0, 10'd1023, 16'h0000);
      send(OP_WRITE, 10'd1023, 10'd0, 10'd682, 16'h5555);
      send(OP_SIFT, 10'd1023, 10'd1023, 10'd341, 16'hAAAA);
      send(OP_READ, 10'd1023, 10'd0, 10'd0, 16'h0000);
      send(OP_SIFT, 10'd0, 10'd1023, 10'd1023, 16'hFFFF);
      send(OP_READ, 10'd0, 10'd1023, 10'd1023, 16'hFFFF);
      send(OP_SIFT, 10'd1, 10'd0, 10'd0, 16'h0000);
      send(OP_WRITE, 10'd1, 10'd0, 10'd341, 16'd7);
      send(OP_WRITE, 10'd2, 10'd0, 10'd100, 16'd7);
      send(OP_WRITE, 10'd3, 10'd0, 10'd200, 16'd9);
      send(OP_SIFT, 10'd1, 10'd3, 10'd0, 16'h0000);
      send(OP_WRITE, 10'd3, 10'd0, 10'd200, 16'd2);
      send(OP_SIFT, 10'd1, 10'd3, 10'd0, 16'h0000);
      send(OP_QUERY, 10'd0, 10'd0, 10'd341, 16'h0000);
      send(OP_READ, 10'd3, 10'd0, 10'd0, 16'h0000);

      while (beats_in < ITEM_TARGET) begin
         choice = $urandom_range(0, 9);
         if (choice < 5) begin
            if (!big_done && beats_in < ITEM_TARGET - BIG_BUDGET &&
                $urandom_range(0, 7) == 0) begin
               big_done = 1'b1;
               build_and_drain($urandom_range(100, 160));
            end else begin
               build_and_drain($urandom_range(2, 24));
            end
         end else if (choice < 6) begin
            deep_path();
         end else begin
            repeat ($urandom_range(4, 12)) noise_item();
         end
      end
      req_valid <= 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.fails == 0 && tracker.pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
